// ===== design/jrsp_pkg.sv =====
// Shared types, constants and helpers for the job record stream parser.
// Used by jrsp_step and by the top level job_record_stream_parser.
package jrsp_pkg;

   localparam int unsigned CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RECORD_LEN = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ATTR_COUNT = CSR_INDEX_W'(1);

   localparam logic [31:0] MAX_RECORD_LEN_RESET = 32'(256 * 1024 * 1024);
   localparam logic [31:0] MAX_ATTR_COUNT_RESET = 32'd8388608;
   localparam logic [31:0] META_BYTES           = 32'(4 + 8 + 4 + 4 + 4 + 4 + 4);

   typedef enum logic [3:0] {
      PH_HDR, PH_PLEN, PH_PATH, PH_PTERM, PH_CLEN, PH_CONT, PH_META,
      PH_KLEN, PH_KEY, PH_KTERM, PH_VLEN, PH_VAL, PH_TRAIL, PH_DISC
   } phase_type;

   localparam logic [3:0] KIND_EOS = 4'd14;

   localparam logic [3:0] NUM_RECLEN     = 4'd0;
   localparam logic [3:0] NUM_PATHLEN    = 4'd1;
   localparam logic [3:0] NUM_CONTENTLEN = 4'd2;
   localparam logic [3:0] NUM_MODE       = 4'd3;
   localparam logic [3:0] NUM_KEYLEN     = 4'd10;
   localparam logic [3:0] NUM_VALLEN     = 4'd11;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_LEN   = 3'd1;
   localparam logic [2:0] ST_OVERRUN   = 3'd2;
   localparam logic [2:0] ST_TOO_MANY  = 3'd3;
   localparam logic [2:0] ST_TRUNCATED = 3'd4;
   localparam logic [2:0] ST_CLEAN_END = 3'd5;

   localparam logic [2:0] META_MTIME = 3'd1;
   localparam logic [2:0] META_COUNT = 3'd6;

   // Byte size of each metadata field; only mtime is eight bytes wide.
   function automatic logic [3:0] meta_size(logic [2:0] field);
      case (field)
         META_MTIME: meta_size = 4'd8;
         default:    meta_size = 4'd4;
      endcase
   endfunction

   typedef struct packed {
      phase_type   phase;
      logic [31:0] record_left;
      logic [31:0] field_left;
      logic [3:0]  number_bytes;
      logic [63:0] number_accum;
      logic [2:0]  meta_field;
      logic [31:0] attrs_left;
      logic [31:0] attr_count_seen;
   } parse_state_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  byte_out;
      logic [3:0]  number_id;
      logic [63:0] number_value;
      logic        number_done;
      logic [31:0] attr_index;
      logic        record_done;
      logic [2:0]  status;
   } result_type;

endpackage

// ===== design/job_record_stream_parser.sv =====
// Top level of the job record stream parser: handshakes, configuration
// registers, parse state and the result register. Depends on jrsp_pkg, jrsp_step.

// The parser takes one stream word per clock while req_stall is low and gives exactly one result
// per word, registered in the cycle after it is taken; a new word can follow every cycle unless stalled.
// The parser has a single result register: req_stall is high only while
// a held result is stalled on the output side. Configuration writes are
// always taken (csr_ready is high) and must be made while the parser is idle.
module job_record_stream_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [7:0]                           req_byte_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [3:0]                           rsp_kind,
   output logic [7:0]                           rsp_byte_out,
   output logic [3:0]                           rsp_number_id,
   output logic [63:0]                          rsp_number_value,
   output logic                                 rsp_number_done,
   output logic [31:0]                          rsp_attr_index,
   output logic                                 rsp_record_done,
   output logic [2:0]                           rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [jrsp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_data
);
   import jrsp_pkg::*;

   parse_state_type state_ff, state_in;
   result_type      result_ff, result_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     max_record_len_ff, max_attr_count_ff;
   logic            accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   jrsp_step u_step (
      .cur_state      (state_ff),
      .action         (req_action),
      .byte_in        (req_byte_in),
      .max_record_len (max_record_len_ff),
      .max_attr_count (max_attr_count_ff),
      .next_state     (state_in),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
         max_record_len_ff <= MAX_RECORD_LEN_RESET;
         max_attr_count_ff <= MAX_ATTR_COUNT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAX_RECORD_LEN) begin
               max_record_len_ff <= csr_data;
            end else if (csr_index == CSR_MAX_ATTR_COUNT) begin
               max_attr_count_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = result_ff.kind;
   assign rsp_byte_out     = result_ff.byte_out;
   assign rsp_number_id    = result_ff.number_id;
   assign rsp_number_value = result_ff.number_value;
   assign rsp_number_done  = result_ff.number_done;
   assign rsp_attr_index   = result_ff.attr_index;
   assign rsp_record_done  = result_ff.record_done;
   assign rsp_status       = result_ff.status;

endmodule

// ===== design/jrsp_step.sv =====
// Next-state and result logic for one stream word of the record parser.
// Purely combinational; depends on jrsp_pkg.
module jrsp_step (
   input  jrsp_pkg::parse_state_type cur_state,
   input  logic                      action,
   input  logic [7:0]                byte_in,
   input  logic [31:0]               max_record_len,
   input  logic [31:0]               max_attr_count,
   output jrsp_pkg::parse_state_type next_state,
   output jrsp_pkg::result_type      result
);
   import jrsp_pkg::*;

   logic [63:0] accum_new;
   logic [4:0]  bytes_new;
   logic [31:0] left_new;
   logic [31:0] field_dec;
   logic [31:0] pairs_new;
   logic [2:0]  meta_clamp;
   phase_type   ph;
   logic [2:0]  status;
   logic        done;
   logic [63:0] value;
   logic [3:0]  id;
   logic        term;

   assign accum_new = {cur_state.number_accum[55:0], byte_in};
   assign bytes_new = {1'b0, cur_state.number_bytes} + 5'd1;
   assign field_dec = (cur_state.field_left != 32'd0) ? cur_state.field_left - 32'd1 : 32'd0;
   assign pairs_new = cur_state.attrs_left - 32'd1;
   assign meta_clamp = (cur_state.meta_field > META_COUNT) ? META_COUNT : cur_state.meta_field;

   always_comb begin
      next_state = cur_state;
      result     = '0;
      ph         = cur_state.phase;
      status     = ST_OK;
      done       = 1'b0;
      value      = '0;
      id         = NUM_RECLEN;
      term       = 1'b0;
      left_new   = cur_state.record_left;

      if (action) begin
         next_state  = '0;
         result.kind = KIND_EOS;
         status = (cur_state.phase == PH_HDR && cur_state.number_bytes == 4'd0) ?
                  ST_CLEAN_END : ST_TRUNCATED;
      end else if (cur_state.phase == PH_HDR) begin
         result.kind              = 4'(cur_state.phase);
         next_state.number_accum  = accum_new;
         next_state.number_bytes  = bytes_new[3:0];
         if (bytes_new >= 5'd4) begin
            done  = 1'b1;
            value = accum_new;
            next_state.number_bytes = '0;
            next_state.number_accum = '0;
            if (value == 64'd0 || value > {32'd0, max_record_len}) begin
               status = ST_BAD_LEN;
            end else begin
               next_state.record_left = value[31:0];
               next_state.phase       = PH_PLEN;
            end
         end
      end else begin
         result.kind = 4'(cur_state.phase);
         if (cur_state.phase inside {[PH_KLEN:PH_VAL]}) begin
            result.attr_index = cur_state.attr_count_seen;
         end
         if (cur_state.phase == PH_META && cur_state.meta_field == 3'd0 &&
             cur_state.number_bytes == 4'd0 && cur_state.record_left < META_BYTES) begin
            result.kind = 4'(PH_DISC);
            status      = ST_OVERRUN;
            ph          = PH_DISC;
         end
         if (cur_state.record_left != 32'd0) begin
            left_new = cur_state.record_left - 32'd1;
         end
         next_state.record_left = left_new;

         case (ph)
            PH_PLEN, PH_CLEN, PH_KLEN, PH_VLEN: begin
               next_state.number_accum = accum_new;
               next_state.number_bytes = bytes_new[3:0];
               if (bytes_new >= 5'd4) begin
                  done  = 1'b1;
                  value = accum_new;
                  term  = (ph == PH_PLEN || ph == PH_KLEN);
                  case (ph)
                     PH_PLEN: id = NUM_PATHLEN;
                     PH_CLEN: id = NUM_CONTENTLEN;
                     PH_KLEN: id = NUM_KEYLEN;
                     default: id = NUM_VALLEN;
                  endcase
                  next_state.number_bytes = '0;
                  next_state.number_accum = '0;
                  if ({1'b0, value} + 65'(term) > {33'd0, left_new}) begin
                     status = ST_OVERRUN;
                     ph     = PH_DISC;
                  end else begin
                     next_state.field_left = value[31:0];
                     case (ph)
                        PH_PLEN: ph = (value != 64'd0) ? PH_PATH : PH_PTERM;
                        PH_KLEN: ph = (value != 64'd0) ? PH_KEY : PH_KTERM;
                        PH_CLEN: begin
                           next_state.meta_field = '0;
                           ph = (value != 64'd0) ? PH_CONT : PH_META;
                        end
                        default: begin
                           if (value != 64'd0) begin
                              ph = PH_VAL;
                           end else begin
                              next_state.attr_count_seen = cur_state.attr_count_seen + 32'd1;
                              next_state.attrs_left      = pairs_new;
                              ph = (pairs_new != 32'd0) ? PH_KLEN : PH_TRAIL;
                           end
                        end
                     endcase
                  end
               end
            end
            PH_PATH, PH_KEY: begin
               next_state.field_left = field_dec;
               if (field_dec == 32'd0) begin
                  ph = (ph == PH_PATH) ? PH_PTERM : PH_KTERM;
               end
            end
            PH_PTERM: ph = PH_CLEN;
            PH_KTERM: ph = PH_VLEN;
            PH_CONT: begin
               next_state.field_left = field_dec;
               if (field_dec == 32'd0) begin
                  next_state.meta_field = '0;
                  ph = PH_META;
               end
            end
            PH_VAL: begin
               next_state.field_left = field_dec;
               if (field_dec == 32'd0) begin
                  next_state.attr_count_seen = cur_state.attr_count_seen + 32'd1;
                  next_state.attrs_left      = pairs_new;
                  ph = (pairs_new != 32'd0) ? PH_KLEN : PH_TRAIL;
               end
            end
            PH_META: begin
               next_state.number_accum = accum_new;
               next_state.number_bytes = bytes_new[3:0];
               if (bytes_new >= {1'b0, meta_size(cur_state.meta_field)}) begin
                  done  = 1'b1;
                  value = accum_new;
                  id    = NUM_MODE + {1'b0, meta_clamp};
                  next_state.number_bytes = '0;
                  next_state.number_accum = '0;
                  if (cur_state.meta_field >= META_COUNT) begin
                     next_state.meta_field = '0;
                     if (value > {32'd0, max_attr_count}) begin
                        status = ST_TOO_MANY;
                        ph     = PH_DISC;
                     end else begin
                        next_state.attrs_left      = value[31:0];
                        next_state.attr_count_seen = '0;
                        ph = (value != 64'd0) ? PH_KLEN : PH_TRAIL;
                     end
                  end else begin
                     next_state.meta_field = cur_state.meta_field + 3'd1;
                  end
               end
            end
            default: begin
            end
         endcase

         next_state.phase = ph;
         result.byte_out  = byte_in;
         if (left_new == 32'd0) begin
            result.record_done = 1'b1;
            if (status == ST_OK && ph != PH_TRAIL && ph != PH_DISC) begin
               status = ST_OVERRUN;
            end
            next_state = '0;
         end
      end

      if (!action && cur_state.phase == PH_HDR) begin
         result.byte_out = byte_in;
      end
      result.status       = status;
      result.number_done  = done;
      result.number_id    = done ? id : 4'd0;
      result.number_value = done ? value : 64'd0;
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for job_record_stream_parser: streams framed job records, broken records and
// end-of-stream marks through the parser and checks every result word against a predictor.
// Depends on jrsp_pkg and the parser RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import jrsp_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic        req_action  = 1'b0;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [3:0]  rsp_kind;
   logic [7:0]  rsp_byte_out;
   logic [3:0]  rsp_number_id;
   logic [63:0] rsp_number_value;
   logic        rsp_number_done;
   logic [31:0] rsp_attr_index;
   logic        rsp_record_done;
   logic [2:0]  rsp_status;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_data    = '0;

   job_record_stream_parser dut (.*);

   always #5 clock = ~clock;

   // Parser state as predicted from the accepted words.
   phase_type   cur_phase;
   logic [31:0] body_left;
   logic [31:0] field_remain;
   logic [3:0]  num_count;
   logic [63:0] num_acc;
   logic [2:0]  meta_idx;
   logic [31:0] pairs_left;
   logic [31:0] pairs_seen;
   logic [31:0] rec_limit;
   logic [31:0] attr_limit;

   result_type  pending_results[$];
   logic [7:0]  body_q[$];
   logic [7:0]  stream_q[$];
   int          words_sent    = 0;
   int          mismatches    = 0;
   int          cycle_count   = 0;
   int          hold_request  = 0;
   bit          req_idle_en   = 1'b1;
   bit          rsp_idle_en   = 1'b1;

   function automatic void clear_state();
      cur_phase    = PH_HDR;
      body_left    = '0;
      field_remain = '0;
      num_count    = '0;
      num_acc      = '0;
      meta_idx     = '0;
      pairs_left   = '0;
      pairs_seen   = '0;
   endfunction

   function automatic bit take_byte(input logic [7:0] b, input int unsigned size);
      num_acc   = {num_acc[55:0], b};
      num_count = num_count + 4'd1;
      return num_count >= size;
   endfunction

   function automatic logic [63:0] pop_number();
      logic [63:0] val;
      val       = num_acc;
      num_acc   = '0;
      num_count = '0;
      return val;
   endfunction

   function automatic void end_pair();
      pairs_seen = pairs_seen + 1;
      pairs_left = pairs_left - 1;
      cur_phase  = (pairs_left != 0) ? PH_KLEN : PH_TRAIL;
   endfunction

   function automatic result_type parse_word(input logic act, input logic [7:0] b);
      result_type  r;
      logic [63:0] val;
      logic        term;
      r = '0;
      if (act) begin
         r.kind   = KIND_EOS;
         r.status = (cur_phase == PH_HDR && num_count == 4'd0) ? ST_CLEAN_END : ST_TRUNCATED;
         clear_state();
         return r;
      end
      r.kind     = 4'(cur_phase);
      r.byte_out = b;
      if (cur_phase == PH_HDR) begin
         if (take_byte(b, 4)) begin
            val = pop_number();
            r.number_done  = 1'b1;
            r.number_id    = NUM_RECLEN;
            r.number_value = val;
            if (val == 0 || val > {32'd0, rec_limit}) begin
               r.status = ST_BAD_LEN;
            end else begin
               body_left = val[31:0];
               cur_phase = PH_PLEN;
            end
         end
         return r;
      end
      if (cur_phase >= PH_KLEN && cur_phase <= PH_VAL) r.attr_index = pairs_seen;
      if (cur_phase == PH_META && meta_idx == 0 && num_count == 0 && body_left < META_BYTES) begin
         r.kind    = 4'(PH_DISC);
         r.status  = ST_OVERRUN;
         cur_phase = PH_DISC;
      end
      if (body_left != 0) body_left = body_left - 1;
      case (cur_phase)
         PH_PLEN, PH_CLEN, PH_KLEN, PH_VLEN: begin
            if (take_byte(b, 4)) begin
               term = (cur_phase == PH_PLEN || cur_phase == PH_KLEN);
               val  = pop_number();
               r.number_done  = 1'b1;
               r.number_value = val;
               r.number_id    = (cur_phase == PH_PLEN) ? NUM_PATHLEN :
                                (cur_phase == PH_CLEN) ? NUM_CONTENTLEN :
                                (cur_phase == PH_KLEN) ? NUM_KEYLEN : NUM_VALLEN;
               if (val + 64'(term) > {32'd0, body_left}) begin
                  r.status  = ST_OVERRUN;
                  cur_phase = PH_DISC;
               end else begin
                  field_remain = val[31:0];
                  case (cur_phase)
                     PH_PLEN: cur_phase = (val != 0) ? PH_PATH : PH_PTERM;
                     PH_KLEN: cur_phase = (val != 0) ? PH_KEY : PH_KTERM;
                     PH_CLEN: begin
                        meta_idx  = '0;
                        cur_phase = (val != 0) ? PH_CONT : PH_META;
                     end
                     default: begin
                        if (val != 0) cur_phase = PH_VAL;
                        else end_pair();
                     end
                  endcase
               end
            end
         end
         PH_PATH, PH_KEY: begin
            if (field_remain != 0) field_remain = field_remain - 1;
            if (field_remain == 0) cur_phase = (cur_phase == PH_PATH) ? PH_PTERM : PH_KTERM;
         end
         PH_PTERM: cur_phase = PH_CLEN;
         PH_KTERM: cur_phase = PH_VLEN;
         PH_CONT: begin
            if (field_remain != 0) field_remain = field_remain - 1;
            if (field_remain == 0) begin
               meta_idx  = '0;
               cur_phase = PH_META;
            end
         end
         PH_VAL: begin
            if (field_remain != 0) field_remain = field_remain - 1;
            if (field_remain == 0) end_pair();
         end
         PH_META: begin
            if (take_byte(b, (meta_idx == META_MTIME) ? 8 : 4)) begin
               val = pop_number();
               r.number_done  = 1'b1;
               r.number_value = val;
               r.number_id    = NUM_MODE + 4'(meta_idx);
               if (meta_idx >= META_COUNT) begin
                  meta_idx = '0;
                  if (val > {32'd0, attr_limit}) begin
                     r.status  = ST_TOO_MANY;
                     cur_phase = PH_DISC;
                  end else begin
                     pairs_left = val[31:0];
                     pairs_seen = '0;
                     cur_phase  = (val != 0) ? PH_KLEN : PH_TRAIL;
                  end
               end else begin
                  meta_idx = meta_idx + 3'd1;
               end
            end
         end
         default: ;
      endcase
      if (body_left == 0) begin
         r.record_done = 1'b1;
         if (r.status == ST_OK && cur_phase != PH_TRAIL && cur_phase != PH_DISC)
            r.status = ST_OVERRUN;
         clear_state();
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want, got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result word arrived with no word pending");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("byte_out", want.byte_out, rsp_byte_out);
            check_field("number_id", want.number_id, rsp_number_id);
            check_field("number_value", want.number_value, rsp_number_value);
            check_field("number_done", want.number_done, rsp_number_done);
            check_field("attr_index", want.attr_index, rsp_attr_index);
            check_field("record_done", want.record_done, rsp_record_done);
            check_field("status", want.status, rsp_status);
         end
      end
   end

   // The receiver stalls a random number of cycles before each result while rsp_idle_en is
   // set, or for a long stretch when one is requested.
   initial begin
      int n;
      forever begin
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
         end else begin
            n = rsp_idle_en ? $urandom_range(0, 4) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send_word(input logic act, input logic [7:0] b);
      int gap;
      gap = req_idle_en ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_byte_in <= b;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(parse_word(act, b));
      words_sent++;
   endtask

   task automatic send_eos();
      send_word(1'b1, 8'($urandom));
   endtask

   task automatic send_stream();
      foreach (stream_q[i]) send_word(1'b0, stream_q[i]);
      stream_q.delete();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_limits(input logic [31:0] rec_lim, input logic [31:0] attr_lim);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_MAX_RECORD_LEN;
      csr_data  <= rec_lim;
      do @(posedge clock); while (!csr_ready);
      rec_limit = rec_lim;
      csr_index <= CSR_MAX_ATTR_COUNT;
      csr_data  <= attr_lim;
      do @(posedge clock); while (!csr_ready);
      attr_limit = attr_lim;
      csr_valid <= 1'b0;
   endtask

   task automatic put_be(input logic [63:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) body_q.push_back(v[8*i +: 8]);
   endtask

   task automatic put_random(input int n);
      repeat (n) body_q.push_back(8'($urandom));
   endtask

   task automatic put_meta(input logic [31:0] count);
      put_be($urandom, 4);
      put_be({$urandom, $urandom}, 8);
      repeat (4) put_be($urandom, 4);
      put_be(count, 4);
   endtask

   task automatic build_body(input int plen, input int clen, input logic [31:0] count,
                             input int npairs, input int kmax, input int vmax, input int trail);
      int klen;
      int vlen;
      put_be(plen, 4);
      put_random(plen + 1);
      put_be(clen, 4);
      put_random(clen);
      put_meta(count);
      repeat (npairs) begin
         klen = $urandom_range(0, kmax);
         vlen = $urandom_range(0, vmax);
         put_be(klen, 4);
         put_random(klen + 1);
         put_be(vlen, 4);
         put_random(vlen);
      end
      put_random(trail);
   endtask

   task automatic frame_body(input logic [31:0] len);
      for (int i = 3; i >= 0; i--) stream_q.push_back(len[8*i +: 8]);
      foreach (body_q[i]) stream_q.push_back(body_q[i]);
      body_q.delete();
   endtask

   task automatic test_stream_ends();
      send_eos();
      stream_q = {8'h00, 8'h00};
      send_stream();
      send_eos();
      frame_body(32'd0);
      frame_body(MAX_RECORD_LEN_RESET + 32'd1);
      put_random(3);
      frame_body(MAX_RECORD_LEN_RESET);
      send_stream();
      send_eos();
   endtask

   task automatic test_well_formed();
      build_body(0, 0, 0, 0, 0, 0, 0);
      frame_body(body_q.size());
      build_body(3, 5, 2, 2, 3, 4, 2);
      frame_body(body_q.size());
      build_body(1, 0, 1, 1, 0, 0, 0);
      frame_body(body_q.size());
      send_stream();
      send_eos();
   endtask

   task automatic test_overruns();
      put_be(4, 4);
      put_random(4);
      frame_body(8);
      put_be(32'hFFFF_FFFF, 4);
      put_random(4);
      frame_body(8);
      put_be(3, 4);
      put_random(4);
      frame_body(8);
      put_be(0, 4);
      put_random(1);
      put_be(9, 4);
      put_random(3);
      frame_body(body_q.size());
      put_be(0, 4);
      put_random(1);
      put_be(0, 4);
      put_random(10);
      frame_body(body_q.size());
      put_be(0, 4);
      put_random(1);
      put_be(0, 4);
      put_meta(1);
      put_be(50, 4);
      put_random(2);
      frame_body(body_q.size());
      put_be(0, 4);
      put_random(1);
      put_be(0, 4);
      put_meta(1);
      put_be(1, 4);
      put_random(2);
      put_be(40, 4);
      put_random(2);
      frame_body(body_q.size());
      put_be(0, 4);
      put_random(1);
      put_be(2, 4);
      put_random(2);
      frame_body(body_q.size());
      put_random(1);
      frame_body(1);
      send_stream();
   endtask

   task automatic test_attr_limits();
      set_limits(MAX_RECORD_LEN_RESET, 32'd2);
      build_body(1, 1, 3, 3, 2, 2, 0);
      frame_body(body_q.size());
      build_body(1, 1, 2, 2, 2, 2, 1);
      frame_body(body_q.size());
      send_stream();
      set_limits(MAX_RECORD_LEN_RESET, 32'd0);
      build_body(0, 0, 0, 0, 0, 0, 1);
      frame_body(body_q.size());
      build_body(0, 0, 1, 1, 0, 0, 0);
      frame_body(body_q.size());
      send_stream();
      set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      build_body(0, 0, 32'hFFFF_FFFF, 1, 2, 2, 0);
      frame_body(body_q.size());
      put_random(6);
      frame_body(32'hFFFF_FFFF);
      send_stream();
      send_eos();
      set_limits(32'd1, 32'd0);
      put_random(1);
      frame_body(1);
      frame_body(2);
      send_stream();
      send_eos();
      set_limits(MAX_RECORD_LEN_RESET, MAX_ATTR_COUNT_RESET);
   endtask

   task automatic test_backpressure();
      drain();
      req_idle_en  = 1'b0;
      rsp_idle_en  = 1'b0;
      hold_request = 40;
      build_body(4, 6, 3, 3, 3, 4, 2);
      frame_body(body_q.size());
      send_stream();
      drain();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   task automatic test_random_streams();
      int          start;
      int          pick;
      int          npairs;
      int          idx;
      logic [31:0] rec_lim;
      logic [31:0] attr_lim;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               rec_lim  = MAX_RECORD_LEN_RESET;
               attr_lim = MAX_ATTR_COUNT_RESET;
            end
            1: begin
               rec_lim  = $urandom_range(100, 400);
               attr_lim = $urandom_range(0, 3);
            end
            2: begin
               rec_lim  = 32'hFFFF_FFFF;
               attr_lim = 32'hFFFF_FFFF;
            end
            3: begin
               rec_lim  = 32'd60;
               attr_lim = 32'd1;
            end
            default: begin
               rec_lim  = $urandom;
               attr_lim = $urandom;
               if (rec_lim == 0) rec_lim = 32'd1;
            end
         endcase
         set_limits(rec_lim, attr_lim);
         start = words_sent;
         while (words_sent - start < 100) begin
            req_idle_en = ($urandom_range(0, 3) != 0);
            rsp_idle_en = ($urandom_range(0, 3) != 0);
            pick   = $urandom_range(0, 9);
            npairs = $urandom_range(0, 3);
            build_body($urandom_range(0, 6), $urandom_range(0, 8), npairs, npairs, 3, 5,
                       $urandom_range(0, 3));
            frame_body(body_q.size());
            if (pick == 7) begin
               idx = $urandom_range(0, stream_q.size() - 1);
               stream_q[idx] = stream_q[idx] ^ 8'($urandom_range(1, 255));
            end else if (pick == 8) begin
               idx = $urandom_range(1, stream_q.size() - 1);
               while (stream_q.size() > idx) void'(stream_q.pop_back());
            end else if (pick == 9) begin
               stream_q.delete();
               repeat ($urandom_range(1, 8)) stream_q.push_back(8'($urandom));
            end
            send_stream();
            if (pick >= 6) send_eos();
         end
      end
   endtask

   initial begin
      clear_state();
      rec_limit  = MAX_RECORD_LEN_RESET;
      attr_limit = MAX_ATTR_COUNT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_stream_ends();
      test_well_formed();
      test_overruns();
      test_attr_limits();
      test_backpressure();
      test_random_streams();
      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
